@@ hdl/swec_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window event counter package
// Shared constants and the back-end sequencer state type.
// ----------------------------------------------------------------------------
package swec_pkg;

  localparam int WIN_BITS = 32;
  localparam logic [WIN_BITS-1:0] WINDOW_RESET = 32'd3000;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [0:0] {
    ST_LOAD,
    ST_CHECK
  } swec_state_t;

endpackage

@@ hdl/swec_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window event counter front end
// Holds the window length and classifies each incoming stamp: whether any
// stored stamp can be stale, and the lower limit of the window.
// ----------------------------------------------------------------------------
module swec_front
  import swec_pkg::*;
#(
  parameter int STAMP_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [WIN_BITS-1:0]     cfg_wr_data,
  input  logic [31:0]             event_time,
  output logic                    trim_en,
  output logic [STAMP_BITS-1:0]   limit,
  output logic [STAMP_BITS-1:0]   now
);

  localparam int CMP_W = (STAMP_BITS > WIN_BITS) ? STAMP_BITS : WIN_BITS;

  logic [WIN_BITS-1:0] window_length;
  logic [CMP_W-1:0]    now_ext;
  logic [CMP_W-1:0]    win_ext;
  logic [CMP_W-1:0]    diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
    end else if (cfg_wr_en) begin
      window_length <= cfg_wr_data;
    end
  end

  always_comb begin
    now     = STAMP_BITS'(event_time);
    now_ext = CMP_W'(now);
    win_ext = CMP_W'(window_length);
    trim_en = (now_ext >= win_ext);
    diff    = now_ext - win_ext;
    limit   = diff[STAMP_BITS-1:0];
  end

endmodule

@@ hdl/swec_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window event counter queue
// A short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module swec_queue
  import swec_pkg::*;
#(
  parameter int WIDTH = 65
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [WIDTH-1:0] entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

@@ hdl/swec_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window event counter back end
// Keeps the stamp ring in a memory, drops stale stamps from the oldest end
// one per cycle, appends the new stamp and registers the result.
// ----------------------------------------------------------------------------
module swec_back
  import swec_pkg::*;
#(
  parameter int STORE_DEPTH = 4096,
  parameter int STAMP_BITS  = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_valid,
  output logic                                   q_ready,
  input  logic                                   q_trim_en,
  input  logic [STAMP_BITS-1:0]                  q_limit,
  input  logic [STAMP_BITS-1:0]                  q_now,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [$clog2(STORE_DEPTH + 1)-1:0]     recent_count,
  output logic                                   overflow
);

  localparam int PTR_W   = $clog2(STORE_DEPTH);
  localparam int COUNT_W = $clog2(STORE_DEPTH + 1);
  localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(STORE_DEPTH - 1);
  localparam logic [COUNT_W-1:0] DEPTH_C  = COUNT_W'(STORE_DEPTH);

  logic [STAMP_BITS-1:0] mem [STORE_DEPTH];
  logic [STAMP_BITS-1:0] rd_data;
  logic [PTR_W-1:0]      rd_addr;
  logic                  mem_we;

  swec_state_t           state, state_next;
  logic [PTR_W-1:0]      head, head_next;
  logic [PTR_W-1:0]      tail, tail_next;
  logic [COUNT_W-1:0]    occupancy, occupancy_next;
  logic                  out_valid_next;
  logic [COUNT_W-1:0]    recent_count_next;
  logic                  overflow_next;
  logic                  trim_en;
  logic [STAMP_BITS-1:0] limit;
  logic [STAMP_BITS-1:0] now;
  logic                  load;
  logic                  stale;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    if (p == PTR_LAST) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    state_next        = state;
    head_next         = head;
    tail_next         = tail;
    occupancy_next    = occupancy;
    out_valid_next    = out_valid && !out_ready;
    recent_count_next = recent_count;
    overflow_next     = overflow;
    q_ready           = 1'b0;
    load              = 1'b0;
    mem_we            = 1'b0;
    stale             = 1'b0;
    rd_addr           = head;
    case (state)
      ST_LOAD: begin
        q_ready = 1'b1;
        if (q_valid) begin
          load       = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        stale = trim_en && (occupancy != '0) && (rd_data < limit);
        if (stale) begin
          head_next      = ring_next(head);
          occupancy_next = occupancy - 1'b1;
          rd_addr        = ring_next(head);
        end else if (!out_valid || out_ready) begin
          mem_we         = 1'b1;
          tail_next      = ring_next(tail);
          out_valid_next = 1'b1;
          state_next     = ST_LOAD;
          if (occupancy == DEPTH_C) begin
            head_next         = ring_next(head);
            overflow_next     = 1'b1;
            recent_count_next = DEPTH_C;
          end else begin
            occupancy_next    = occupancy + 1'b1;
            overflow_next     = 1'b0;
            recent_count_next = occupancy + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      head      <= '0;
      tail      <= '0;
      occupancy <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      occupancy <= occupancy_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    recent_count <= recent_count_next;
    overflow     <= overflow_next;
    if (load) begin
      trim_en <= q_trim_en;
      limit   <= q_limit;
      now     <= q_now;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= now;
    end
    rd_data <= mem[rd_addr];
  end

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= DEPTH_C)
    else $error("occupancy exceeds store depth");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> recent_count != '0)
    else $error("result count is zero");

  a_ovf_saturated: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> recent_count == DEPTH_C)
    else $error("overflow without a full store");

  a_pop_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK && stale) |=> occupancy == $past(occupancy) - 1'b1)
    else $error("stale pop did not reduce occupancy by one");
`endif

endmodule

@@ hdl/sliding_window_event_counter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window event counter
// Counts the events whose stamps fall within an inclusive look-back window.
// ----------------------------------------------------------------------------
// Each event beat passes through the back end's load and check states; the
// check state removes stale stamps from the ring one per cycle, because the
// ring memory has one read port and only the oldest stamp is checked. Each
// stamp is removed at most once. A two-entry queue lets the input keep
// accepting beats while the back end works or the result waits. The stamp
// memory needs no clearing after reset, and the window length may be written
// only while the block is idle.
module sliding_window_event_counter_top
  import swec_pkg::*;
#(
  parameter int STORE_DEPTH = 4096,
  parameter int STAMP_BITS  = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [WIN_BITS-1:0]                 cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [31:0]                         event_time,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [$clog2(STORE_DEPTH + 1)-1:0]  recent_count,
  output logic                                overflow
);

  localparam int QW = 2 * STAMP_BITS + 1;

  logic                  f_trim_en;
  logic [STAMP_BITS-1:0] f_limit;
  logic [STAMP_BITS-1:0] f_now;
  logic                  q_valid;
  logic                  q_ready;
  logic [QW-1:0]         q_data;

  swec_front #(
    .STAMP_BITS (STAMP_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .event_time  (event_time),
    .trim_en     (f_trim_en),
    .limit       (f_limit),
    .now         (f_now)
  );

  swec_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  ({f_trim_en, f_limit, f_now}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  swec_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .STAMP_BITS  (STAMP_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_trim_en    (q_data[QW-1]),
    .q_limit      (q_data[QW-2:STAMP_BITS]),
    .q_now        (q_data[STAMP_BITS-1:0]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .recent_count (recent_count),
    .overflow     (overflow)
  );

endmodule
